FILE: hw/rtl/mips3d_pkg.sv
// ----------------------------------------------------------------------------
// mips3d_pkg
// Shared types, codes and decode tables of the MIPS III instruction decoder.
// ----------------------------------------------------------------------------
package mips3d_pkg;

    localparam int WORD_W  = 32;
    localparam int ID_W    = 8;
    localparam int SLOT_W  = 6;
    localparam int TDATA_W = 8;
    localparam int TUSER_W = 8;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [4:0] RS_BC      = 5'h08;

    typedef enum logic [2:0] {
        CLS_REG     = 3'd0,
        CLS_IMM     = 3'd1,
        CLS_JUMP    = 3'd2,
        CLS_BRANCH  = 3'd3,
        CLS_SPECIAL = 3'd4
    } instr_class_t;

    typedef enum logic [3:0] {
        GRP_MAIN      = 4'd0,
        GRP_SPECIAL   = 4'd1,
        GRP_REGIMM    = 4'd2,
        GRP_COP0_MOVE = 4'd3,
        GRP_COP0_BR   = 4'd4,
        GRP_COP0_FUNC = 4'd5,
        GRP_COP1_MOVE = 4'd6,
        GRP_COP1_BR   = 4'd7,
        GRP_COP1_FUNC = 4'd8
    } group_t;

    typedef struct packed {
        group_t              group;
        logic [SLOT_W-1:0]   slot;
    } group_slot_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        instr_class_t        cls;
    } dec_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        instr_class_t        cls;
        logic                known;
        group_t              group;
    } dec_result_t;

    function automatic dec_entry_t lookup_main(input logic [SLOT_W-1:0] slot);
        dec_entry_t e;
        e = '{id: 8'd0, cls: CLS_REG};
        unique case (slot)
            6'h02: e = '{8'd1,  CLS_JUMP};
            6'h03: e = '{8'd2,  CLS_JUMP};
            6'h04: e = '{8'd3,  CLS_BRANCH};
            6'h05: e = '{8'd4,  CLS_BRANCH};
            6'h06: e = '{8'd5,  CLS_BRANCH};
            6'h07: e = '{8'd6,  CLS_BRANCH};
            6'h08: e = '{8'd7,  CLS_IMM};
            6'h09: e = '{8'd8,  CLS_IMM};
            6'h0A: e = '{8'd9,  CLS_IMM};
            6'h0B: e = '{8'd10, CLS_IMM};
            6'h0C: e = '{8'd11, CLS_IMM};
            6'h0D: e = '{8'd12, CLS_IMM};
            6'h0E: e = '{8'd13, CLS_IMM};
            6'h0F: e = '{8'd14, CLS_IMM};
            6'h14: e = '{8'd15, CLS_BRANCH};
            6'h15: e = '{8'd16, CLS_BRANCH};
            6'h16: e = '{8'd17, CLS_BRANCH};
            6'h17: e = '{8'd18, CLS_BRANCH};
            6'h18: e = '{8'd19, CLS_IMM};
            6'h19: e = '{8'd20, CLS_IMM};
            6'h1A: e = '{8'd21, CLS_IMM};
            6'h1B: e = '{8'd22, CLS_IMM};
            6'h20: e = '{8'd23, CLS_IMM};
            6'h21: e = '{8'd24, CLS_IMM};
            6'h22: e = '{8'd25, CLS_IMM};
            6'h23: e = '{8'd26, CLS_IMM};
            6'h24: e = '{8'd27, CLS_IMM};
            6'h25: e = '{8'd28, CLS_IMM};
            6'h26: e = '{8'd29, CLS_IMM};
            6'h27: e = '{8'd30, CLS_IMM};
            6'h28: e = '{8'd31, CLS_IMM};
            6'h29: e = '{8'd32, CLS_IMM};
            6'h2A: e = '{8'd33, CLS_IMM};
            6'h2B: e = '{8'd34, CLS_IMM};
            6'h2C: e = '{8'd35, CLS_IMM};
            6'h2D: e = '{8'd36, CLS_IMM};
            6'h2E: e = '{8'd37, CLS_IMM};
            6'h2F: e = '{8'd38, CLS_SPECIAL};
            6'h30: e = '{8'd39, CLS_IMM};
            6'h31: e = '{8'd40, CLS_IMM};
            6'h34: e = '{8'd41, CLS_IMM};
            6'h35: e = '{8'd42, CLS_IMM};
            6'h37: e = '{8'd43, CLS_IMM};
            6'h38: e = '{8'd44, CLS_IMM};
            6'h39: e = '{8'd45, CLS_IMM};
            6'h3C: e = '{8'd46, CLS_IMM};
            6'h3D: e = '{8'd47, CLS_IMM};
            6'h3F: e = '{8'd48, CLS_IMM};
            default: e = '{8'd0, CLS_REG};
        endcase
        return e;
    endfunction

    function automatic dec_entry_t lookup_special(input logic [SLOT_W-1:0] slot);
        dec_entry_t e;
        e = '{id: 8'd0, cls: CLS_REG};
        unique case (slot)
            6'h00: e = '{8'd49,  CLS_REG};
            6'h02: e = '{8'd50,  CLS_REG};
            6'h03: e = '{8'd51,  CLS_REG};
            6'h04: e = '{8'd52,  CLS_REG};
            6'h06: e = '{8'd53,  CLS_REG};
            6'h07: e = '{8'd54,  CLS_REG};
            6'h08: e = '{8'd55,  CLS_REG};
            6'h09: e = '{8'd56,  CLS_REG};
            6'h0C: e = '{8'd57,  CLS_SPECIAL};
            6'h0D: e = '{8'd58,  CLS_SPECIAL};
            6'h0F: e = '{8'd59,  CLS_SPECIAL};
            6'h10: e = '{8'd60,  CLS_REG};
            6'h11: e = '{8'd61,  CLS_REG};
            6'h12: e = '{8'd62,  CLS_REG};
            6'h13: e = '{8'd63,  CLS_REG};
            6'h14: e = '{8'd64,  CLS_REG};
            6'h16: e = '{8'd65,  CLS_REG};
            6'h17: e = '{8'd66,  CLS_REG};
            6'h18: e = '{8'd67,  CLS_REG};
            6'h19: e = '{8'd68,  CLS_REG};
            6'h1A: e = '{8'd69,  CLS_REG};
            6'h1B: e = '{8'd70,  CLS_REG};
            6'h1C: e = '{8'd71,  CLS_REG};
            6'h1D: e = '{8'd72,  CLS_REG};
            6'h1E: e = '{8'd73,  CLS_REG};
            6'h1F: e = '{8'd74,  CLS_REG};
            6'h20: e = '{8'd75,  CLS_REG};
            6'h21: e = '{8'd76,  CLS_REG};
            6'h22: e = '{8'd77,  CLS_REG};
            6'h23: e = '{8'd78,  CLS_REG};
            6'h24: e = '{8'd79,  CLS_REG};
            6'h25: e = '{8'd80,  CLS_REG};
            6'h26: e = '{8'd81,  CLS_REG};
            6'h27: e = '{8'd82,  CLS_REG};
            6'h2A: e = '{8'd83,  CLS_REG};
            6'h2B: e = '{8'd84,  CLS_REG};
            6'h2C: e = '{8'd85,  CLS_REG};
            6'h2D: e = '{8'd86,  CLS_REG};
            6'h2E: e = '{8'd87,  CLS_REG};
            6'h2F: e = '{8'd88,  CLS_REG};
            6'h30: e = '{8'd89,  CLS_REG};
            6'h31: e = '{8'd90,  CLS_REG};
            6'h32: e = '{8'd91,  CLS_REG};
            6'h33: e = '{8'd92,  CLS_REG};
            6'h34: e = '{8'd93,  CLS_REG};
            6'h36: e = '{8'd94,  CLS_REG};
            6'h38: e = '{8'd95,  CLS_REG};
            6'h3A: e = '{8'd96,  CLS_REG};
            6'h3B: e = '{8'd97,  CLS_REG};
            6'h3C: e = '{8'd98,  CLS_REG};
            6'h3E: e = '{8'd99,  CLS_REG};
            6'h3F: e = '{8'd100, CLS_REG};
            default: e = '{8'd0, CLS_REG};
        endcase
        return e;
    endfunction

    function automatic dec_entry_t lookup_regimm(input logic [SLOT_W-1:0] slot);
        dec_entry_t e;
        e = '{id: 8'd0, cls: CLS_IMM};
        unique case (slot)
            6'h00: e = '{8'd101, CLS_BRANCH};
            6'h01: e = '{8'd102, CLS_BRANCH};
            6'h02: e = '{8'd103, CLS_BRANCH};
            6'h03: e = '{8'd104, CLS_BRANCH};
            6'h08: e = '{8'd105, CLS_IMM};
            6'h09: e = '{8'd106, CLS_IMM};
            6'h0A: e = '{8'd107, CLS_IMM};
            6'h0B: e = '{8'd108, CLS_IMM};
            6'h0C: e = '{8'd109, CLS_IMM};
            6'h0E: e = '{8'd110, CLS_IMM};
            6'h10: e = '{8'd111, CLS_BRANCH};
            6'h11: e = '{8'd112, CLS_BRANCH};
            6'h12: e = '{8'd113, CLS_BRANCH};
            6'h13: e = '{8'd114, CLS_BRANCH};
            default: e = '{8'd0, CLS_IMM};
        endcase
        return e;
    endfunction

    function automatic dec_entry_t lookup_cop0(input group_t group,
                                               input logic [SLOT_W-1:0] slot);
        dec_entry_t e;
        e = '{id: 8'd0, cls: CLS_REG};
        if (group == GRP_COP0_MOVE)
        begin
            unique case (slot)
                6'h00: e = '{8'd115, CLS_REG};
                6'h01: e = '{8'd116, CLS_REG};
                6'h04: e = '{8'd117, CLS_REG};
                6'h05: e = '{8'd118, CLS_REG};
                default: e = '{8'd0, CLS_REG};
            endcase
        end
        else if (group == GRP_COP0_FUNC)
        begin
            unique case (slot)
                6'h01: e = '{8'd119, CLS_SPECIAL};
                6'h02: e = '{8'd120, CLS_SPECIAL};
                6'h06: e = '{8'd121, CLS_SPECIAL};
                6'h08: e = '{8'd122, CLS_SPECIAL};
                6'h18: e = '{8'd123, CLS_SPECIAL};
                default: e = '{8'd0, CLS_SPECIAL};
            endcase
        end
        else
        begin
            unique case (slot)
                6'h00: e = '{8'd124, CLS_BRANCH};
                6'h01: e = '{8'd125, CLS_BRANCH};
                6'h02: e = '{8'd126, CLS_BRANCH};
                6'h03: e = '{8'd127, CLS_BRANCH};
                default: e = '{8'd0, CLS_BRANCH};
            endcase
        end
        return e;
    endfunction

    function automatic dec_entry_t lookup_cop1(input group_t group,
                                               input logic [SLOT_W-1:0] slot);
        dec_entry_t e;
        e = '{id: 8'd0, cls: CLS_REG};
        if (group == GRP_COP1_MOVE)
        begin
            unique case (slot)
                6'h00: e = '{8'd128, CLS_REG};
                6'h01: e = '{8'd129, CLS_REG};
                6'h02: e = '{8'd130, CLS_REG};
                6'h04: e = '{8'd131, CLS_REG};
                6'h05: e = '{8'd132, CLS_REG};
                6'h06: e = '{8'd133, CLS_REG};
                default: e = '{8'd0, CLS_REG};
            endcase
        end
        else if (group == GRP_COP1_BR)
        begin
            unique case (slot)
                6'h00: e = '{8'd134, CLS_BRANCH};
                6'h01: e = '{8'd135, CLS_BRANCH};
                6'h02: e = '{8'd136, CLS_BRANCH};
                6'h03: e = '{8'd137, CLS_BRANCH};
                default: e = '{8'd0, CLS_BRANCH};
            endcase
        end
        else
        begin
            unique case (slot)
                6'h00: e = '{8'd138, CLS_REG};
                6'h01: e = '{8'd139, CLS_REG};
                6'h02: e = '{8'd140, CLS_REG};
                6'h03: e = '{8'd141, CLS_REG};
                6'h04: e = '{8'd142, CLS_REG};
                6'h05: e = '{8'd143, CLS_REG};
                6'h06: e = '{8'd144, CLS_REG};
                6'h07: e = '{8'd145, CLS_REG};
                6'h08: e = '{8'd146, CLS_REG};
                6'h09: e = '{8'd147, CLS_REG};
                6'h0A: e = '{8'd148, CLS_REG};
                6'h0B: e = '{8'd149, CLS_REG};
                6'h0C: e = '{8'd150, CLS_REG};
                6'h0D: e = '{8'd151, CLS_REG};
                6'h0E: e = '{8'd152, CLS_REG};
                6'h0F: e = '{8'd153, CLS_REG};
                6'h20: e = '{8'd154, CLS_REG};
                6'h21: e = '{8'd155, CLS_REG};
                6'h24: e = '{8'd156, CLS_REG};
                6'h25: e = '{8'd157, CLS_REG};
                6'h30: e = '{8'd158, CLS_REG};
                6'h31: e = '{8'd159, CLS_REG};
                6'h32: e = '{8'd160, CLS_REG};
                6'h33: e = '{8'd161, CLS_REG};
                6'h34: e = '{8'd162, CLS_REG};
                6'h35: e = '{8'd163, CLS_REG};
                6'h36: e = '{8'd164, CLS_REG};
                6'h37: e = '{8'd165, CLS_REG};
                6'h38: e = '{8'd166, CLS_REG};
                6'h39: e = '{8'd167, CLS_REG};
                6'h3A: e = '{8'd168, CLS_REG};
                6'h3B: e = '{8'd169, CLS_REG};
                6'h3C: e = '{8'd170, CLS_REG};
                6'h3D: e = '{8'd171, CLS_REG};
                6'h3E: e = '{8'd172, CLS_REG};
                6'h3F: e = '{8'd173, CLS_REG};
                default: e = '{8'd0, CLS_SPECIAL};
            endcase
        end
        return e;
    endfunction

endpackage

FILE: hw/rtl/mips3d_group_sel.sv
// ----------------------------------------------------------------------------
// mips3d_group_sel
// Picks the decode group of an instruction word and the slot inside it.
// ----------------------------------------------------------------------------
module mips3d_group_sel (
    input  logic [mips3d_pkg::WORD_W-1:0] word,
    output mips3d_pkg::group_slot_t       sel
);
    import mips3d_pkg::*;

    logic [5:0] opcode;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [5:0] funct;
    logic       is_cop1;

    assign opcode  = word[31:26];
    assign rs      = word[25:21];
    assign rt      = word[20:16];
    assign funct   = word[5:0];
    assign is_cop1 = (opcode == OP_COP1);

    always_comb
    begin
        priority if (opcode == OP_SPECIAL)
        begin
            sel.group = GRP_SPECIAL;
            sel.slot  = funct;
        end
        else if (opcode == OP_REGIMM)
        begin
            sel.group = GRP_REGIMM;
            sel.slot  = {1'b0, rt};
        end
        else if (opcode == OP_COP0 || opcode == OP_COP1)
        begin
            if (rs == RS_BC)
            begin
                sel.group = is_cop1 ? GRP_COP1_BR : GRP_COP0_BR;
                sel.slot  = {1'b0, rt};
            end
            else if (rs[4])
            begin
                sel.group = is_cop1 ? GRP_COP1_FUNC : GRP_COP0_FUNC;
                sel.slot  = funct;
            end
            else
            begin
                sel.group = is_cop1 ? GRP_COP1_MOVE : GRP_COP0_MOVE;
                sel.slot  = {1'b0, rs};
            end
        end
        else
        begin
            sel.group = GRP_MAIN;
            sel.slot  = opcode;
        end
    end

endmodule

FILE: hw/rtl/mips3d_lookup.sv
// ----------------------------------------------------------------------------
// mips3d_lookup
// Looks up instruction identity and class for a group and slot.
// ----------------------------------------------------------------------------
module mips3d_lookup (
    input  mips3d_pkg::group_slot_t sel,
    output mips3d_pkg::dec_result_t result
);
    import mips3d_pkg::*;

    dec_entry_t entry;

    always_comb
    begin
        unique case (sel.group)
            GRP_MAIN:      entry = lookup_main(sel.slot);
            GRP_SPECIAL:   entry = lookup_special(sel.slot);
            GRP_REGIMM:    entry = lookup_regimm(sel.slot);
            GRP_COP0_MOVE,
            GRP_COP0_BR,
            GRP_COP0_FUNC: entry = lookup_cop0(sel.group, sel.slot);
            GRP_COP1_MOVE,
            GRP_COP1_BR,
            GRP_COP1_FUNC: entry = lookup_cop1(sel.group, sel.slot);
            default:       entry = '{id: 8'd0, cls: CLS_REG};
        endcase
    end

    assign result.id    = entry.id;
    assign result.cls   = entry.cls;
    assign result.known = (entry.id != '0);
    assign result.group = sel.group;

endmodule

FILE: hw/rtl/mips3_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// mips3_instruction_decoder_unit
// Decodes one MIPS III instruction word per request into an identity
// (1..173, 0 when undefined), a class, a known flag and the decode group
// consulted. Words are taken into an input register, decoded by table logic
// and held in a result register: one request per clock cycle is sustained
// while m_tready is high, and an empty input register takes the next word
// while a result waits on the output side.
// ----------------------------------------------------------------------------
module mips3_instruction_decoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mips3d_pkg::WORD_W-1:0]  s_tdata,   // instr_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mips3d_pkg::TDATA_W-1:0] m_tdata,   // instr_id
    output logic [mips3d_pkg::TUSER_W-1:0] m_tuser    // instr_class, known, group_sel
);
    import mips3d_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [WORD_W-1:0] in_word_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    dec_result_t       out_result_reg;
    logic              advance;
    group_slot_t       sel;
    dec_result_t       result;

    mips3d_group_sel u_group_sel (
        .word (in_word_reg),
        .sel  (sel)
    );

    mips3d_lookup u_lookup (
        .sel    (sel),
        .result (result)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.id;
    assign m_tuser  = {out_result_reg.group, out_result_reg.known, out_result_reg.cls};

    a_known_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[3] == (m_tdata != 8'd0)))
        else $error("known flag disagrees with instruction id");

    a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[7:4] <= 4'd8))
        else $error("group select out of range");

    a_take_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted request not held in input register");

    a_move_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> m_tvalid)
        else $error("decoded request lost before result register");

endmodule
